### hw/rtl/dss_pkg.sv
// Package for the diffusion stencil step block: field widths, register indexes,
// reset values and limits shared by the RTL.
// Depends on nothing.
package dss_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int SAMPLE_W       = 32;
   localparam int SUM_W          = 55;
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int GAIN_W         = 23;
   localparam int CSR_DATA_W     = 23;
   localparam int CSR_INDEX_W    = 2;

   localparam int LAP_W  = SAMPLE_W + 4;
   localparam int MAG_W  = SAMPLE_W + 3;
   localparam int PROD_W = MAG_W + GAIN_W;
   localparam int RND_W  = PROD_W + 1 - 24;
   localparam int NV_W   = SAMPLE_W + 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN         = 2'd2;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd2048;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd2048;
   localparam logic [GAIN_W-1:0]         GAIN_RST         = 23'd16777;
   localparam logic [GAIN_W-1:0]         GAIN_MAX         = 23'd4194304;
   localparam logic [PROD_W:0]           ROUND_HALF       = (PROD_W+1)'(1) << 23;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;

endpackage

### hw/rtl/diffusion_stencil_step.sv
// Top level of the diffusion stencil step: line stores, window, Laplacian,
// gain multiply, saturation and change accumulation in one pipeline.
// Depends on dss_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_sample, req_frame_start
//   rsp      out        rsp_valid/rsp_ready    rsp_new_value, rsp_abs_change,
//                                              rsp_change_sum, rsp_last_in_frame
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One transaction is accepted per cycle while stage one can load; a result
// passes stage one, the window, multiply, saturation and result registers.
// Each stage holds only when the stage after it is full and stalled, so bubbles
// are squeezed out and input is still taken while a result waits on rsp_ready.
// Synchronous reset clears the position, the accumulator and the pipeline valid
// bits and sets the CSRs to their reset values; the line stores are not cleared.
module diffusion_stencil_step #(
   parameter int MAX_WIDTH  = dss_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dss_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dss_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dss_pkg::SAMPLE_W-1:0]       rsp_new_value,
   output logic [dss_pkg::SAMPLE_W-1:0]       rsp_abs_change,
   output logic [dss_pkg::SUM_W-1:0]          rsp_change_sum,
   output logic                               rsp_last_in_frame,
   input  logic                               csr_we,
   input  logic [dss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dss_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int RAW   = $clog2(MAX_HEIGHT);
   localparam int RCW   = $clog2(MAX_HEIGHT + 1);

   // Configuration registers.
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [CNT_W-1:0]          eff_w;
   logic [RCW-1:0]            eff_h;
   logic [GAIN_W-1:0]         eff_gain;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         gain_ff         <= GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
            CSR_GAIN:         gain_ff         <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (32'(frame_width_ff) < 32'd3) begin
         eff_w = CNT_W'(3);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CNT_W'(MAX_WIDTH);
      end else begin
         eff_w = CNT_W'(frame_width_ff);
      end
      if (32'(frame_height_ff) < 32'd3) begin
         eff_h = RCW'(3);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = RCW'(MAX_HEIGHT);
      end else begin
         eff_h = RCW'(frame_height_ff);
      end
      eff_gain = (gain_ff > GAIN_MAX) ? GAIN_MAX : gain_ff;
   end

   // Stage enables: a stage loads when it is empty or its content moves on.
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, rsp_valid_ff;
   logic p1_en, p2_en, p3_en, p4_en, out_en, accept;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign p4_en     = !p4_valid_ff || out_en;
   assign p3_en     = !p3_valid_ff || p4_en;
   assign p2_en     = !p2_valid_ff || p3_en;
   assign p1_en     = !p1_valid_ff || p2_en;
   assign req_ready = p1_en;
   assign accept    = req_valid && p1_en;

   // Raster position.
   logic [AW-1:0]    col_ff, col_in, c0, c1;
   logic [RAW-1:0]   row_ff, row_in, r0, r1, r0_next, r1_next;
   logic [CNT_W-1:0] c1_inc;
   logic [RCW-1:0]   r0_inc, r1_inc;
   logic             wrap0, end_row, s0_produce, s0_last, s0_clear;

   always_comb begin
      c0      = req_frame_start ? '0 : col_ff;
      r0      = req_frame_start ? '0 : row_ff;
      wrap0   = CNT_W'(c0) >= eff_w;
      r0_inc  = RCW'(r0) + RCW'(1);
      r0_next = (r0_inc >= eff_h) ? '0 : r0_inc[RAW-1:0];
      c1      = wrap0 ? '0 : c0;
      r1      = wrap0 ? r0_next : r0;
      c1_inc  = CNT_W'(c1) + CNT_W'(1);
      end_row = c1_inc >= eff_w;
      r1_inc  = RCW'(r1) + RCW'(1);
      r1_next = (r1_inc >= eff_h) ? '0 : r1_inc[RAW-1:0];
      col_in  = end_row ? '0 : c1_inc[AW-1:0];
      row_in  = end_row ? r1_next : r1;
      s0_produce = (RCW'(r1) >= RCW'(2)) && (RCW'(r1) < eff_h) && (CNT_W'(c1) >= CNT_W'(2));
      s0_last    = (RCW'(r1) == eff_h - RCW'(1)) && (CNT_W'(c1) == eff_w - CNT_W'(1));
      s0_clear   = (r1 == '0) && (c1 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores and stage one.
   sample_type row_above_mem [MAX_WIDTH];
   sample_type two_rows_above_mem [MAX_WIDTH];
   sample_type rd_above_ff, rd_above2_ff, fwd_above_ff, fwd_above2_ff;
   logic       fwd_ff;
   logic [AW-1:0] p1_col_ff;
   sample_type p1_sample_ff, p1_above, p1_above2;
   logic       p1_produce_ff, p1_last_ff, p1_clear_ff, p1_done;

   assign p1_done   = p1_valid_ff && p2_en;
   assign p1_above  = fwd_ff ? fwd_above_ff : rd_above_ff;
   assign p1_above2 = fwd_ff ? fwd_above2_ff : rd_above2_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_above_ff  <= row_above_mem[c1];
         rd_above2_ff <= two_rows_above_mem[c1];
      end
      if (p1_done) begin
         row_above_mem[p1_col_ff]      <= p1_sample_ff;
         two_rows_above_mem[p1_col_ff] <= p1_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_en) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff        <= p1_done && (p1_col_ff == c1);
         fwd_above_ff  <= p1_sample_ff;
         fwd_above2_ff <= p1_above;
         p1_col_ff     <= c1;
         p1_sample_ff  <= req_sample;
         p1_produce_ff <= s0_produce;
         p1_last_ff    <= s0_last;
         p1_clear_ff   <= s0_clear;
      end
   end

   // Window and Laplacian.
   sample_type win1_ff, win2_ff, win3_ff, win4_ff;
   logic [LAP_W-1:0] lap;
   logic [LAP_W-1:0] p2_lap_ff;
   sample_type p2_center_ff;
   logic       p2_produce_ff, p2_last_ff, p2_clear_ff;

   assign lap = LAP_W'(win3_ff) + LAP_W'(win4_ff) + LAP_W'(win1_ff) + LAP_W'(p1_above)
              - {2'b00, win2_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (p1_done) begin
         win1_ff       <= win2_ff;
         win2_ff       <= p1_above;
         win3_ff       <= p1_above2;
         win4_ff       <= p1_sample_ff;
         p2_lap_ff     <= lap;
         p2_center_ff  <= win2_ff;
         p2_produce_ff <= p1_produce_ff;
         p2_last_ff    <= p1_last_ff;
         p2_clear_ff   <= p1_clear_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_en) begin
         p2_valid_ff <= p1_valid_ff && (p1_produce_ff || p1_clear_ff);
      end
   end

   // Gain multiply on the magnitude of the Laplacian.
   logic [LAP_W-1:0]  lap_abs;
   logic [PROD_W-1:0] p3_prod_ff;
   logic              p3_neg_ff, p3_produce_ff, p3_last_ff, p3_clear_ff;
   sample_type        p3_center_ff;

   assign lap_abs = p2_lap_ff[LAP_W-1] ? (~p2_lap_ff + LAP_W'(1)) : p2_lap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (p3_en) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_en && p2_valid_ff) begin
         p3_prod_ff    <= PROD_W'(lap_abs[MAG_W-1:0]) * PROD_W'(eff_gain);
         p3_neg_ff     <= p2_lap_ff[LAP_W-1];
         p3_center_ff  <= p2_center_ff;
         p3_produce_ff <= p2_produce_ff;
         p3_last_ff    <= p2_last_ff;
         p3_clear_ff   <= p2_clear_ff;
      end
   end

   // Rounding, update and saturation.
   logic [PROD_W:0]  rnd_sum;
   logic [RND_W-1:0] rnd;
   logic [NV_W-1:0]  nv;
   sample_type       new_value, diff, p4_new_ff, p4_diff_ff;
   logic             p4_produce_ff, p4_last_ff, p4_clear_ff;

   always_comb begin
      rnd_sum = {1'b0, p3_prod_ff} + ROUND_HALF;
      rnd     = rnd_sum[PROD_W:24];
      if (p3_neg_ff) begin
         nv = NV_W'(p3_center_ff) - NV_W'(rnd);
      end else begin
         nv = NV_W'(p3_center_ff) + NV_W'(rnd);
      end
      if (nv[NV_W-1]) begin
         new_value = '0;
      end else if (nv[NV_W-2:SAMPLE_W] != '0) begin
         new_value = '1;
      end else begin
         new_value = nv[SAMPLE_W-1:0];
      end
      diff = (new_value >= p3_center_ff) ? (new_value - p3_center_ff)
                                         : (p3_center_ff - new_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (p4_en) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p4_en && p3_valid_ff) begin
         p4_new_ff     <= new_value;
         p4_diff_ff    <= p3_produce_ff ? diff : '0;
         p4_produce_ff <= p3_produce_ff;
         p4_last_ff    <= p3_last_ff;
         p4_clear_ff   <= p3_clear_ff;
      end
   end

   // Change accumulation and result register.
   sum_type            acc_ff, acc_base;
   logic [SUM_W:0]     acc_sum;
   sum_type            acc_in;
   sample_type         rsp_new_ff, rsp_diff_ff;
   logic               rsp_last_ff;

   always_comb begin
      acc_base = p4_clear_ff ? '0 : acc_ff;
      acc_sum  = {1'b0, acc_base} + (SUM_W+1)'(p4_diff_ff);
      acc_in   = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else if (out_en) begin
         rsp_valid_ff <= p4_valid_ff && p4_produce_ff;
         if (p4_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && p4_valid_ff) begin
         rsp_new_ff  <= p4_new_ff;
         rsp_diff_ff <= p4_diff_ff;
         rsp_last_ff <= p4_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_value     = rsp_new_ff;
   assign rsp_abs_change    = rsp_diff_ff;
   assign rsp_change_sum    = acc_ff;
   assign rsp_last_in_frame = rsp_last_ff;

endmodule

### sim/diffusion_stencil_step_checker.sv
// Checker for the diffusion stencil step: follows the register writes and the
// accepted cells, predicts every interior result and compares it field by field.
// Depends on dss_pkg.
`timescale 1ns / 100ps
module diffusion_stencil_step_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [dss_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              req_frame_start,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [dss_pkg::SAMPLE_W-1:0]      rsp_new_value,
   input  logic [dss_pkg::SAMPLE_W-1:0]      rsp_abs_change,
   input  logic [dss_pkg::SUM_W-1:0]         rsp_change_sum,
   input  logic                              rsp_last_in_frame,
   input  logic                              csr_we,
   input  logic [dss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   import dss_pkg::*;

   localparam longint          SAMPLE_TOP = 64'h0000_0000_FFFF_FFFF;
   localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_W) - 1;
   localparam int              LINE_AW    = $clog2(MAX_WIDTH_DEF);

   typedef struct {
      sample_type new_value;
      sample_type abs_change;
      sum_type    change_sum;
      logic       last_in_frame;
   } cell_update_type;

   cell_update_type pending_updates[$];

   sample_type upper_line [MAX_WIDTH_DEF];
   sample_type upper_line2 [MAX_WIDTH_DEF];
   sample_type west_cell, centre_cell, east_cell, north_cell, south_cell;
   int unsigned row_pos, col_pos;
   sum_type change_total;
   logic [FRAME_WIDTH_W-1:0]  width_setting;
   logic [FRAME_HEIGHT_W-1:0] height_setting;
   logic [GAIN_W-1:0]         gain_setting;
   int error_total = 0;

   function automatic void diffuse_cell(input sample_type sample_in, input logic restart);
      int unsigned w, h, col, row;
      longint unsigned g, mag, total;
      longint lap, centre_val, next_val;
      sample_type above, above2, new_val, delta;
      cell_update_type upd;
      w = 32'(width_setting);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = 32'(height_setting);
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      g = 64'((gain_setting > GAIN_MAX) ? GAIN_MAX : gain_setting);
      if (restart) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end
      col = col_pos;
      row = row_pos;
      if (row == 0 && col == 0) change_total = '0;
      above = upper_line[col[LINE_AW-1:0]];
      above2 = upper_line2[col[LINE_AW-1:0]];
      west_cell = centre_cell;
      centre_cell = east_cell;
      east_cell = above;
      if (row >= 2 && row < h && col >= 2) begin
         lap = {32'd0, north_cell} + {32'd0, south_cell} + {32'd0, west_cell}
             + {32'd0, east_cell} - ({32'd0, centre_cell} << 2);
         mag = (lap < 0) ? -lap : lap;
         mag = (mag * g + (64'd1 << 23)) >> 24;
         centre_val = longint'({32'd0, centre_cell});
         next_val = (lap < 0) ? centre_val - longint'(mag) : centre_val + longint'(mag);
         if (next_val < 0) next_val = 0;
         else if (next_val > SAMPLE_TOP) next_val = SAMPLE_TOP;
         new_val = next_val[SAMPLE_W-1:0];
         delta = (new_val >= centre_cell) ? new_val - centre_cell : centre_cell - new_val;
         total = 64'(change_total);
         total = total + 64'(delta);
         if (total > SUM_LIMIT) total = SUM_LIMIT;
         change_total = total[SUM_W-1:0];
         upd.new_value = new_val;
         upd.abs_change = delta;
         upd.change_sum = change_total;
         upd.last_in_frame = (row == h - 1 && col == w - 1);
         pending_updates.push_back(upd);
      end
      north_cell = above2;
      south_cell = sample_in;
      upper_line2[col[LINE_AW-1:0]] = above;
      upper_line[col[LINE_AW-1:0]] = sample_in;
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   task automatic flag_error(input string what, input logic [63:0] got,
                             input logic [63:0] want);
      $display("ERROR at %0t: %s is %h, expected %h", $time, what, got, want);
      error_total++;
   endtask

   always @(posedge clock) begin
      cell_update_type want;
      if (reset) begin
         row_pos = 0;
         col_pos = 0;
         change_total = '0;
         west_cell = '0;
         centre_cell = '0;
         east_cell = '0;
         north_cell = '0;
         south_cell = '0;
         width_setting = FRAME_WIDTH_RST;
         height_setting = FRAME_HEIGHT_RST;
         gain_setting = GAIN_RST;
         pending_updates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH: width_setting = csr_wdata[FRAME_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: height_setting = csr_wdata[FRAME_HEIGHT_W-1:0];
               CSR_GAIN: gain_setting = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) diffuse_cell(req_sample, req_frame_start);
         if (rsp_valid && rsp_ready) begin
            if (pending_updates.size() == 0) begin
               flag_error("unexpected transaction, new_value", 64'(rsp_new_value), 64'd0);
            end else begin
               want = pending_updates.pop_front();
               if (rsp_new_value !== want.new_value)
                  flag_error("new_value", 64'(rsp_new_value), 64'(want.new_value));
               if (rsp_abs_change !== want.abs_change)
                  flag_error("abs_change", 64'(rsp_abs_change), 64'(want.abs_change));
               if (rsp_change_sum !== want.change_sum)
                  flag_error("change_sum", 64'(rsp_change_sum), 64'(want.change_sum));
               if (rsp_last_in_frame !== want.last_in_frame)
                  flag_error("last_in_frame", 64'(rsp_last_in_frame),
                             64'(want.last_in_frame));
            end
         end
      end
      fail_count <= error_total;
      pending <= pending_updates.size();
   end

endmodule

### sim/diffusion_stencil_step_tb.sv
// Testbench top for the diffusion stencil step: clock, reset, register set-up,
// directed and random grid cells, result back-pressure, watchdog and verdict.
// Depends on dss_pkg, diffusion_stencil_step and diffusion_stencil_step_checker.
`timescale 1ns / 100ps
module diffusion_stencil_step_tb;
   import dss_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_CELLS = 250;

   typedef enum int {FILL_RANDOM, FILL_SMOOTH, FILL_EXTREME, FILL_CHECKER} fill_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   sample_type             req_sample = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sample_type             rsp_new_value;
   sample_type             rsp_abs_change;
   sum_type                rsp_change_sum;
   logic                   rsp_last_in_frame;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     fail_count;
   int                     pending;
   bit                     calm = 1'b0;
   bit                     hold_wanted = 1'b0;

   diffusion_stencil_step i_dut (.*);

   diffusion_stencil_step_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      return (v < 3) ? 3 : ((v > hi) ? hi : v);
   endfunction

   function automatic sample_type pick_sample(input fill_style_type style, input sample_type base,
                                              input int unsigned row, input int unsigned col);
      case (style)
         FILL_RANDOM: return $urandom;
         FILL_SMOOTH: return base + $urandom_range(65535) - 32768;
         FILL_EXTREME: begin
            case ($urandom_range(4))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               3: return 32'h7FFF_FFFF;
               default: return 32'h4000_0000;
            endcase
         end
         default: return ((row + col) % 2) ? '1 : '0;
      endcase
   endfunction

   task automatic push_cell(input sample_type sample_in, input bit restart);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= sample_in;
      req_frame_start <= restart;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic send_cells(input int unsigned count, input int unsigned w,
                             input fill_style_type style, input bit restart, input bit broken);
      sample_type base;
      int unsigned k;
      bit fs;
      base = $urandom;
      for (k = 0; k < count; k++) begin
         fs = (k == 0) && restart;
         if (broken && $urandom_range(49) == 0) fs = 1'b1;
         push_cell(pick_sample(style, base, k / w, k % w), fs);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic settle_and_load(input int unsigned w, input int unsigned h,
                                  input int unsigned g);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : result_sink
      int unsigned hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 35);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("diffusion_stencil_step test failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned w, h, g, k, frames, cells, random_cells;
      fill_style_type style;
      bit broken;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      settle_and_load(3, 4, GAIN_MAX);
      send_cells(12, 3, FILL_CHECKER, 1'b1, 1'b0);
      send_cells(2, 3, FILL_EXTREME, 1'b1, 1'b0);
      for (k = 0; k < 12; k++)
         push_cell(((k % 3) == 1 && k >= 3 && k < 9) ? '0 : '1, k == 0);
      send_cells(3, 3, FILL_EXTREME, 1'b0, 1'b0);

      settle_and_load(4095, 1, $urandom_range(GAIN_MAX));
      send_cells(100, MAX_WIDTH_DEF, FILL_SMOOTH, 1'b1, 1'b0);

      settle_and_load(0, 8191, 23'h7F_FFFF);
      send_cells(90, 3, FILL_RANDOM, 1'b1, 1'b0);
      settle_and_load(0, 20, 23'h7F_FFFF);
      send_cells(66, 3, FILL_RANDOM, 1'b0, 1'b0);

      settle_and_load(12, 8, $urandom_range(GAIN_MAX));
      send_cells(69, 12, FILL_SMOOTH, 1'b1, 1'b0);
      settle_and_load(6, 8, $urandom_range(GAIN_MAX));
      send_cells(18, 6, FILL_SMOOTH, 1'b0, 1'b0);

      calm = 1'b1;
      settle_and_load(16, 12, $urandom_range(GAIN_MAX));
      hold_wanted = 1'b1;
      send_cells(16 * 12, 16, FILL_RANDOM, 1'b1, 1'b0);
      calm = 1'b0;

      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         case ($urandom_range(9))
            0: w = $urandom_range(2);
            1: w = $urandom_range(17, 32);
            default: w = $urandom_range(3, 16);
         endcase
         case ($urandom_range(9))
            0: h = $urandom_range(2);
            1: h = $urandom_range(11, 20);
            default: h = $urandom_range(3, 10);
         endcase
         case ($urandom_range(5))
            0: g = 0;
            1: g = GAIN_MAX;
            2: g = $urandom_range(GAIN_MAX + 1, 23'h7F_FFFF);
            3: g = GAIN_RST;
            default: g = $urandom_range(GAIN_MAX);
         endcase
         settle_and_load(w, h, g);
         w = clamp_size(w, MAX_WIDTH_DEF);
         h = clamp_size(h, MAX_HEIGHT_DEF);
         frames = $urandom_range(1, 3);
         for (k = 0; k < frames && random_cells < RANDOM_CELLS; k++) begin
            style = fill_style_type'($urandom_range(3));
            broken = ($urandom_range(6) == 0);
            cells = broken ? $urandom_range(1, w * h) : w * h;
            send_cells(cells, w, style, k == 0 || $urandom_range(3) != 0, broken);
            random_cells += cells;
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("diffusion_stencil_step test passed");
      end else begin
         $display("diffusion_stencil_step test failed");
      end
      $finish;
   end

endmodule
